@@ design/fit_policy_block_allocator_assert.svh @@
// Assertion macros shared by the allocator RTL.
`ifndef FIT_POLICY_BLOCK_ALLOCATOR_ASSERT_SVH
`define FIT_POLICY_BLOCK_ALLOCATOR_ASSERT_SVH

`ifndef SYNTHESIS

// Check a property on every clock edge outside reset.
`define FPBA_ASSERT(label, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("allocator assertion failed");

// Check that a condition holds in the cycle after a trigger.
`define FPBA_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("allocator assertion failed");

`else

`define FPBA_ASSERT(label, prop)
`define FPBA_ASSERT_NEXT(label, ante, cons)

`endif

`endif

@@ design/fpba_pkg.sv @@
// Shared constants, codes and types of the fit-policy block allocator.
`timescale 1ns / 1ps

package fpba_pkg;

    // Table geometry
    localparam int MAX_BLOCKS = 16;
    localparam int SIZE_BITS  = 16;
    localparam int AMT_W      = 16;
    localparam int IDX_W      = $clog2(MAX_BLOCKS);
    localparam int CNT_W      = $clog2(MAX_BLOCKS + 1);
    localparam int TOTAL_W    = SIZE_BITS + IDX_W;
    localparam int CMP_W      = (SIZE_BITS > AMT_W) ? SIZE_BITS : AMT_W;

    // Fit policies; code three falls back to first fit
    localparam logic [1:0] POL_FIRST = 2'd0;
    localparam logic [1:0] POL_BEST  = 2'd1;
    localparam logic [1:0] POL_WORST = 2'd2;

    typedef enum logic [1:0] {
        OP_APPEND = 2'd0,
        OP_ALLOC  = 2'd1,
        OP_CLEAR  = 2'd2
    } opcode_e;

    typedef enum logic [2:0] {
        ST_ALLOC   = 3'd0,
        ST_NOFIT   = 3'd1,
        ST_LOADED  = 3'd2,
        ST_FULL    = 3'd3,
        ST_CLEARED = 3'd4
    } status_e;

    // Broadcast control from the sequencer to every cell
    typedef struct packed {
        logic [AMT_W-1:0]     amount;
        logic [1:0]           policy;
        logic [CNT_W-1:0]     count;
        logic                 wr_en;
        logic [IDX_W-1:0]     wr_idx;
        logic [SIZE_BITS-1:0] wr_data;
    } cell_ctl_t;

    // Candidate block handed from cell to cell
    typedef struct packed {
        logic                 found;
        logic [IDX_W-1:0]     idx;
        logic [SIZE_BITS-1:0] val;
    } cand_t;

endpackage

@@ design/fit_policy_block_allocator.sv @@
// Top level: sequencer, cell chain, running summaries and output register.
// Append, clear and unknown opcodes go straight to the result; allocate first
// scans, as the candidate walks MAX_BLOCKS cells one cell per cycle.
// One transaction is in flight at a time, the next taken once the last finishes;
// a new one is taken while a result waits, and a stalled result holds the next.
// Reset clears block count, summaries, policy and control; entries are not cleared.
`timescale 1ns / 1ps

`include "fit_policy_block_allocator_assert.svh"

module fit_policy_block_allocator (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [1:0]                     cfg_data,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [1:0]                     opcode,
    input  logic [fpba_pkg::AMT_W-1:0]     amount,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [2:0]                     status,
    output logic [fpba_pkg::IDX_W-1:0]     block_index,
    output logic [fpba_pkg::AMT_W-1:0]     block_left,
    output logic [fpba_pkg::CNT_W-1:0]     empty_blocks,
    output logic [fpba_pkg::TOTAL_W-1:0]   free_total
);
    import fpba_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SCAN = 3'b010,
        S_DONE = 3'b100
    } state_t;

    state_t               state_reg, state_next;
    logic [1:0]           policy_reg;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic [1:0]           op_reg;
    logic [AMT_W-1:0]     amt_reg;
    logic [IDX_W-1:0]     scan_cnt_reg, scan_cnt_next;
    logic [TOTAL_W-1:0]   total_reg, total_next;
    logic [CNT_W-1:0]     empty_reg, empty_next;

    logic                 out_valid_reg;
    status_e              status_reg, res_status;
    logic [IDX_W-1:0]     index_reg, res_idx;
    logic [AMT_W-1:0]     left_reg, res_left;
    logic [CNT_W-1:0]     out_empty_reg;
    logic [TOTAL_W-1:0]   out_total_reg;

    logic                 accept;
    logic                 finish;
    logic [SIZE_BITS-1:0] amt_store;
    logic [SIZE_BITS-1:0] new_val;
    logic                 hit;
    logic                 res_is_alloc;
    cell_ctl_t            ctl;
    cand_t                cand_w [MAX_BLOCKS+1];
    cand_t                cand_end;

    assign cfg_ready = 1'b1;
    assign in_ready  = (state_reg == S_IDLE);
    assign accept    = in_valid && in_ready;
    assign finish    = (state_reg == S_DONE) && (!out_valid_reg || out_ready);

    // Chain of cells; the head sees no candidate
    assign cand_w[0] = '0;

    genvar g;
    generate
        for (g = 0; g < MAX_BLOCKS; g++)
        begin : g_cell
            fpba_cell u_cell (
                .clk        (clk),
                .cell_index (IDX_W'(g)),
                .ctl        (ctl),
                .cand_in    (cand_w[g]),
                .cand_out   (cand_w[g+1])
            );
        end
    endgenerate

    assign cand_end = cand_w[MAX_BLOCKS];

    // Judge the candidate at the tail of the chain
    assign amt_store = SIZE_BITS'(amt_reg);
    assign hit       = cand_end.found && (CMP_W'(cand_end.val) >= CMP_W'(amt_reg));
    assign new_val   = SIZE_BITS'(CMP_W'(cand_end.val) - CMP_W'(amt_reg));

    // Work out the result and the table update of the current transaction
    always_comb
    begin
        ctl.amount  = amt_reg;
        ctl.policy  = policy_reg;
        ctl.count   = count_reg;
        ctl.wr_en   = 1'b0;
        ctl.wr_idx  = '0;
        ctl.wr_data = '0;
        res_status  = ST_NOFIT;
        res_idx     = '0;
        res_left    = '0;
        count_next  = count_reg;
        total_next  = total_reg;
        empty_next  = empty_reg;
        case (op_reg)
            OP_APPEND:
            begin
                if (count_reg < CNT_W'(MAX_BLOCKS))
                begin
                    ctl.wr_en   = finish;
                    ctl.wr_idx  = count_reg[IDX_W-1:0];
                    ctl.wr_data = amt_store;
                    res_status  = ST_LOADED;
                    res_idx     = count_reg[IDX_W-1:0];
                    res_left    = AMT_W'(amt_store);
                    count_next  = count_reg + CNT_W'(1);
                    total_next  = total_reg + TOTAL_W'(amt_store);
                    empty_next  = empty_reg + CNT_W'(amt_store == '0);
                end
                else
                begin
                    res_status = ST_FULL;
                end
            end
            OP_ALLOC:
            begin
                if (hit)
                begin
                    ctl.wr_en   = finish;
                    ctl.wr_idx  = cand_end.idx;
                    ctl.wr_data = new_val;
                    res_status  = ST_ALLOC;
                    res_idx     = cand_end.idx;
                    res_left    = AMT_W'(new_val);
                    total_next  = total_reg - TOTAL_W'(amt_reg);
                    empty_next  = empty_reg
                                + CNT_W'((cand_end.val != '0) && (new_val == '0));
                end
            end
            OP_CLEAR:
            begin
                res_status = ST_CLEARED;
                count_next = '0;
                total_next = '0;
                empty_next = '0;
            end
            default:
            begin
                res_status = ST_NOFIT;
            end
        endcase
    end

    // Sequence accept, chain walk and result hand-off
    always_comb
    begin
        state_next    = state_reg;
        scan_cnt_next = scan_cnt_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    scan_cnt_next = '0;
                    state_next    = (opcode == OP_ALLOC) ? S_SCAN : S_DONE;
                end
            end
            S_SCAN:
            begin
                if (scan_cnt_reg == IDX_W'(MAX_BLOCKS - 1))
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    scan_cnt_next = scan_cnt_reg + IDX_W'(1);
                end
            end
            S_DONE:
            begin
                if (finish)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            policy_reg    <= POL_FIRST;
            count_reg     <= '0;
            total_reg     <= '0;
            empty_reg     <= '0;
            scan_cnt_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            scan_cnt_reg <= scan_cnt_next;
            if (cfg_valid && cfg_ready)
            begin
                policy_reg <= cfg_data;
            end
            if (finish)
            begin
                count_reg     <= count_next;
                total_reg     <= total_next;
                empty_reg     <= empty_next;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Transaction and result payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg  <= opcode;
            amt_reg <= amount;
        end
        if (finish)
        begin
            status_reg    <= res_status;
            index_reg     <= res_idx;
            left_reg      <= res_left;
            out_empty_reg <= empty_next;
            out_total_reg <= total_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign status       = status_reg;
    assign block_index  = index_reg;
    assign block_left   = left_reg;
    assign empty_blocks = out_empty_reg;
    assign free_total   = out_total_reg;

    // Flag a waiting allocation result
    assign res_is_alloc = out_valid_reg && (status_reg == ST_ALLOC);

    `FPBA_ASSERT(a_count_bound, count_reg <= CNT_W'(MAX_BLOCKS))
    `FPBA_ASSERT(a_empty_le_count, empty_reg <= count_reg)
    `FPBA_ASSERT_NEXT(a_alloc_scans, accept && (opcode == OP_ALLOC), state_reg == S_SCAN)
    `FPBA_ASSERT(a_alloc_index_loaded, !res_is_alloc || (CNT_W'(index_reg) < count_reg))

endmodule

@@ design/fpba_cell.sv @@
// One table cell: holds a block size and refines the passing candidate.
`timescale 1ns / 1ps

module fpba_cell (
    input  logic                         clk,
    input  logic [fpba_pkg::IDX_W-1:0]   cell_index,
    input  fpba_pkg::cell_ctl_t          ctl,
    input  fpba_pkg::cand_t              cand_in,
    output fpba_pkg::cand_t              cand_out
);
    import fpba_pkg::*;

    logic [SIZE_BITS-1:0] value_reg;
    logic [SIZE_BITS-1:0] value_next;
    cand_t                cand_reg;
    cand_t                cand_next;
    logic                 loaded;
    logic                 fits;
    logic                 take;

    // Decide whether this block replaces the incoming candidate
    always_comb
    begin
        loaded = CNT_W'(cell_index) < ctl.count;
        fits   = CMP_W'(value_reg) >= CMP_W'(ctl.amount);
        case (ctl.policy)
            POL_WORST: take = !cand_in.found || (value_reg > cand_in.val);
            POL_BEST:  take = fits && (!cand_in.found || (value_reg < cand_in.val));
            default:   take = fits && !cand_in.found;
        endcase
        cand_next = cand_in;
        if (take && loaded)
        begin
            cand_next.found = 1'b1;
            cand_next.idx   = cell_index;
            cand_next.val   = value_reg;
        end
    end

    // Load the block size when the sequencer writes this entry
    always_comb
    begin
        value_next = value_reg;
        if (ctl.wr_en && (ctl.wr_idx == cell_index))
        begin
            value_next = ctl.wr_data;
        end
    end

    // Hold the entry and hand the candidate to the next cell
    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
        cand_reg  <= cand_next;
    end

    assign cand_out = cand_reg;

endmodule
